// File: hdl/tea_block_cipher_assert.svh
// Assertion macros for the TEA block cipher. Each macro expects i_clk and
// i_rst_n in the scope of the caller.
`ifndef TEA_BLOCK_CIPHER_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define TBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tea_block_cipher assertion failed");

// Check a consequent in the cycle after its antecedent.
`define TBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tea_block_cipher assertion failed");

`endif

// File: hdl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

    localparam logic [31:0] DELTA = 32'h9e37_79b9;
    localparam int unsigned WordW = 32;
    localparam int unsigned KeyWords = 4;
    localparam int unsigned AddrW = 4;

    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    typedef logic [KeyWords-1:0][WordW-1:0] t_key;

    typedef struct packed {
        logic             opcode;
        logic [WordW-1:0] left_word;
        logic [WordW-1:0] right_word;
    } t_item;

    function automatic logic [WordW-1:0] mix(
        input logic [WordW-1:0] half,
        input logic [WordW-1:0] sum,
        input logic [WordW-1:0] ka,
        input logic [WordW-1:0] kb
    );
        return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
    endfunction

endpackage

// File: hdl/tea_cfg.sv
`timescale 1ns / 1ps

module tea_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tea_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tea_pkg::t_key              o_key
);

    tea_pkg::t_key     r_key;
    tea_pkg::t_key     n_key;
    tea_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = tea_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        if (w_wr) begin
            unique case (w_idx)
                tea_pkg::REG_KEY0: n_key[0] = pwdata;
                tea_pkg::REG_KEY1: n_key[1] = pwdata;
                tea_pkg::REG_KEY2: n_key[2] = pwdata;
                tea_pkg::REG_KEY3: n_key[3] = pwdata;
                default:           n_key = r_key;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tea_pkg::REG_KEY0: prdata = r_key[0];
            tea_pkg::REG_KEY1: prdata = r_key[1];
            tea_pkg::REG_KEY2: prdata = r_key[2];
            tea_pkg::REG_KEY3: prdata = r_key[3];
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

endmodule

// File: hdl/tea_round.sv
`timescale 1ns / 1ps

module tea_round #(
    parameter logic [31:0] SUM_ENC = 32'h0,
    parameter logic [31:0] SUM_DEC = 32'h0,
    parameter bit          HALF    = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tea_pkg::t_item i_item,
    input  tea_pkg::t_key  i_key,
    output logic           o_valid,
    output tea_pkg::t_item o_item
);

    logic           r_valid;
    tea_pkg::t_item r_item;
    logic           n_valid;
    tea_pkg::t_item n_item;
    logic           w_dec;
    logic           w_upd_left;
    logic [31:0]    w_src;
    logic [31:0]    w_dst;
    logic [31:0]    w_ka;
    logic [31:0]    w_kb;
    logic [31:0]    w_sum;
    logic [31:0]    w_mix;
    logic [31:0]    w_new;

    // Encrypt: first half updates left from right, second half right from left.
    // Decrypt runs the same two halves in reverse order with subtraction.
    assign w_dec      = i_item.opcode;
    assign w_upd_left = (HALF == 1'b0) ^ w_dec;
    assign w_src      = w_upd_left ? i_item.right_word : i_item.left_word;
    assign w_dst      = w_upd_left ? i_item.left_word : i_item.right_word;
    assign w_ka       = w_upd_left ? i_key[0] : i_key[2];
    assign w_kb       = w_upd_left ? i_key[1] : i_key[3];
    assign w_sum      = w_dec ? SUM_DEC : SUM_ENC;
    assign w_mix      = tea_pkg::mix(w_src, w_sum, w_ka, w_kb);
    assign w_new      = w_dec ? (w_dst - w_mix) : (w_dst + w_mix);

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (i_en) begin
            n_valid       = i_valid;
            n_item.opcode = i_item.opcode;
            if (w_upd_left) begin
                n_item.left_word  = w_new;
                n_item.right_word = i_item.right_word;
            end else begin
                n_item.left_word  = i_item.left_word;
                n_item.right_word = w_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/tea_skid.sv
`timescale 1ns / 1ps

module tea_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tea_pkg::t_item i_item,
    input  logic           m_tready,
    output logic           o_en,
    output logic           m_tvalid,
    output logic [63:0]    m_tdata
);

    logic           r_hold_valid;
    tea_pkg::t_item r_hold_item;
    logic           n_hold_valid;
    tea_pkg::t_item n_hold_item;
    tea_pkg::t_item w_out;

    assign o_en = ~r_hold_valid;

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold_item  = r_hold_item;
        if (r_hold_valid) begin
            if (m_tready) begin
                n_hold_valid = 1'b0;
            end
        end else if (i_valid && !m_tready) begin
            // park the finished result so the pipeline keeps moving this cycle
            n_hold_valid = 1'b1;
            n_hold_item  = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_item <= n_hold_item;
    end

    assign w_out    = r_hold_valid ? r_hold_item : i_item;
    assign m_tvalid = r_hold_valid | i_valid;
    assign m_tdata  = {w_out.right_word, w_out.left_word};

endmodule

// File: hdl/tea_block_cipher.sv
`timescale 1ns / 1ps

// TEA block cipher, one 64-bit block per cycle. Each TEA cycle is split into
// two half-round register stages, so an item passes through 2*CYCLES stages.
// Its result is driven onto the output straight from the last stage register,
// unless a stalled result is held. A new block is accepted every cycle while
// results are taken. A one-entry hold register at the output absorbs a single
// stalled result, and the whole pipeline holds while it is occupied. The four
// key words are read by every stage directly, so write them over the register
// port only while no block is in flight.
module tea_block_cipher #(
    parameter int CYCLES = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,   // left_word[31:0], right_word[63:32]
    input  logic                      s_tuser,   // opcode[0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,   // left_result[31:0], right_result[63:32]
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tea_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int Stages = 2 * CYCLES;

    tea_pkg::t_key  w_key;
    tea_pkg::t_item w_in_item;
    logic           w_en;
    logic           w_valid [Stages];
    tea_pkg::t_item w_item  [Stages];

    tea_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key)
    );

    assign w_in_item.opcode     = s_tuser;
    assign w_in_item.left_word  = s_tdata[31:0];
    assign w_in_item.right_word = s_tdata[63:32];
    assign s_tready             = w_en;

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        localparam int          Round = s / 2;
        localparam logic [63:0] ProdE = 64'(Round + 1) * 64'(tea_pkg::DELTA);
        localparam logic [63:0] ProdD = 64'(CYCLES - Round) * 64'(tea_pkg::DELTA);

        tea_round #(
            .SUM_ENC (ProdE[31:0]),
            .SUM_DEC (ProdD[31:0]),
            .HALF    ((s % 2) == 1)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid ((s == 0) ? s_tvalid : w_valid[(s == 0) ? 0 : s - 1]),
            .i_item  ((s == 0) ? w_in_item : w_item[(s == 0) ? 0 : s - 1]),
            .i_key   (w_key),
            .o_valid (w_valid[s]),
            .o_item  (w_item[s])
        );
    end

    tea_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[Stages-1]),
        .i_item   (w_item[Stages-1]),
        .m_tready (m_tready),
        .o_en     (w_en),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

`include "tea_block_cipher_assert.svh"

    `TBC_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, w_valid[0])
    `TBC_ASSERT_NEXT(a_hold_drains, !w_en && m_tready, w_en)
    `TBC_ASSERT_NEXT(a_no_hold_when_empty, w_en && !w_valid[Stages-1], w_en)

endmodule

// File: verif/tea_block_cipher_tb.sv
`timescale 1ns / 1ps

module tea_block_cipher_tb;

    localparam int ROUNDS = 32;
    localparam int PIPE_DEPTH = 2 * ROUNDS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BLOCKS = 256;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } tea_op_e;

    typedef struct packed {
        logic [31:0] right;
        logic [31:0] left;
    } tea_block_t;

    typedef logic [31:0] key_set_t [tea_pkg::KeyWords];

    class tea_scoreboard;
        tea_block_t  expected_blocks[$];
        logic [31:0] key[tea_pkg::KeyWords];
        int          mismatches;
        int          requests;
        int          decrypts;
        int          results;

        function new();
            foreach (key[i]) key[i] = '0;
            mismatches = 0;
            requests = 0;
            decrypts = 0;
            results = 0;
        endfunction

        function logic [31:0] half_round(logic [31:0] half, logic [31:0] sum,
                                         logic [31:0] ka, logic [31:0] kb);
            logic [31:0] shl_term;
            logic [31:0] shr_term;
            logic [31:0] sum_term;
            shl_term = {half[27:0], 4'b0000} + ka;
            shr_term = {5'b00000, half[31:5]} + kb;
            sum_term = half + sum;
            return shl_term ^ sum_term ^ shr_term;
        endfunction

        function tea_block_t transform(tea_op_e op, logic [31:0] l, logic [31:0] r);
            logic [31:0] sum;
            tea_block_t  blk;
            if (op == OP_ENCRYPT) begin
                sum = '0;
                repeat (ROUNDS) begin
                    sum = sum + tea_pkg::DELTA;
                    l = l + half_round(r, sum, key[0], key[1]);
                    r = r + half_round(l, sum, key[2], key[3]);
                end
            end else begin
                sum = 32'(ROUNDS) * tea_pkg::DELTA;
                repeat (ROUNDS) begin
                    r = r - half_round(l, sum, key[2], key[3]);
                    l = l - half_round(r, sum, key[0], key[1]);
                    sum = sum - tea_pkg::DELTA;
                end
            end
            blk.left = l;
            blk.right = r;
            return blk;
        endfunction

        function void note_request(tea_op_e op, logic [31:0] l, logic [31:0] r);
            expected_blocks.push_back(transform(op, l, r));
            requests++;
            if (op == OP_DECRYPT) decrypts++;
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [31:0] l, logic [31:0] r);
            tea_block_t want;
            results++;
            if (expected_blocks.size() == 0) begin
                report($sformatf("unexpected result left=%h right=%h", l, r));
            end else begin
                want = expected_blocks.pop_front();
                if (l !== want.left)
                    report($sformatf("left_result %h, expected %h", l, want.left));
                if (r !== want.right)
                    report($sformatf("right_result %h, expected %h", r, want.right));
            end
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [63:0]               s_tdata = '0;  // left_word[31:0], right_word[63:32]
    logic                      s_tuser = 1'b0;  // opcode[0]
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [63:0]               m_tdata;  // left_result[31:0], right_result[63:32]
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [tea_pkg::AddrW-1:0] paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;

    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            cycle_count = 0;
    tea_scoreboard sb = new();

    tea_block_cipher #(
        .CYCLES(ROUNDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata[31:0], m_tdata[63:32]);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_block(tea_op_e op, logic [31:0] l, logic [31:0] r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {r, l};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request(op, l, r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key(tea_pkg::t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.key[idx] = value;
        // read back in a second transfer
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value)
            sb.report($sformatf("key word %0d reads %h, expected %h", idx, prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_keys(key_set_t keys);
        for (int i = 0; i < tea_pkg::KeyWords; i++) write_key(tea_pkg::t_reg_idx'(i), keys[i]);
    endtask

    task automatic run_phase(key_set_t keys, int idle_pct, int stall_pct);
        load_keys(keys);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_BLOCKS; n++)
            push_block(tea_op_e'($urandom_range(1)), $urandom, $urandom);
        drain();
    endtask

    logic [31:0] corner_left[7] = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                                    32'h8000_0000, 32'h0000_0001, 32'h5555_5555};
    logic [31:0] corner_right[7] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                                     32'h0000_0001, 32'h8000_0000, 32'haaaa_aaaa};

    initial begin
        key_set_t keys;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_left[i]) begin
            push_block(OP_ENCRYPT, corner_left[i], corner_right[i]);
            push_block(OP_DECRYPT, corner_left[i], corner_right[i]);
        end
        drain();
        foreach (keys[i]) keys[i] = 32'hffff_ffff;
        load_keys(keys);
        for (int i = 0; i < 5; i++) begin
            push_block(OP_ENCRYPT, corner_left[i], corner_right[i]);
            push_block(OP_DECRYPT, corner_left[i], corner_right[i]);
        end
        drain();

        foreach (keys[i]) keys[i] = $urandom;
        run_phase(keys, 0, 0);
        keys = '{32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'hffff_fffe};
        run_phase(keys, 82, 0);
        foreach (keys[i]) keys[i] = $urandom;
        run_phase(keys, 0, 82);
        foreach (keys[i]) keys[i] = $urandom;
        run_phase(keys, 20, 20);

        recv_stall_pct = 0;
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("run: %0d blocks sent (%0d decrypt), %0d results checked, %0d mismatches",
                 sb.requests, sb.decrypts, sb.results, sb.mismatches);
        $display("run: zero, all-ones, edge-pattern and random keys; mixed sender/receiver stalls");
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
